/* design/rcc_pkg.sv */
// ----------------------------------------------------------------------------
// rcc_pkg: shared types and constants of the RGB 3x3 convolution unit
// Register indexes, field widths, pixel and window types used across modules.
// ----------------------------------------------------------------------------
package rcc_pkg;

    // Default geometry and coefficient format
    localparam int MAX_LINE_DEF   = 1024;
    localparam int COEF_FRAC_DEF  = 10;

    // Configuration register widths and port format
    localparam int WIDTH_REG_W    = 11;
    localparam int HEIGHT_REG_W   = 13;
    localparam int KERNEL_REG_W   = 48;
    localparam int CFG_DATA_W     = 48;
    localparam int CFG_INDEX_W    = 3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_TOP    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MID    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

    // Reset values
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    // Frame geometry
    localparam int ROW_W      = 12;
    localparam int HEIGHT_MAX = 4096;

    // Datapath widths
    localparam int CHAN_W   = 8;
    localparam int PIXEL_W  = 3 * CHAN_W;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = COEF_W + CHAN_W + 1;
    localparam int SUM_W    = PROD_W + 4;
    localparam int TAPS     = 9;
    localparam int CHANNELS = 3;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } pixel_t;

    // Window of taps, tap[row][column], row 0 is the line above centre and
    // column 0 is the left column.
    typedef struct packed {
        pixel_t [2:0][2:0] tap;
        logic              last;
    } window_t;

    // One kernel register per window row; coefficient k sits at bits 16k+15..16k.
    typedef logic [2:0][KERNEL_REG_W-1:0] kernel_t;

    // Select one colour channel of a pixel (0 red, 1 green, 2 blue).
    function automatic chan_t chan_of(input pixel_t p, input int ch);
        chan_t c;
        case (ch)
            0:       c = p.r;
            1:       c = p.g;
            default: c = p.b;
        endcase
        return c;
    endfunction

endpackage

/* design/rcc_if.sv */
// ----------------------------------------------------------------------------
// rcc_if: stream channels of the RGB 3x3 convolution unit
// Pixel input channel and filtered result channel with valid/ready transfer.
// ----------------------------------------------------------------------------
interface rcc_pix_if;
    logic          valid;
    logic          ready;
    rcc_pkg::chan_t red_in;
    rcc_pkg::chan_t green_in;
    rcc_pkg::chan_t blue_in;
    logic          frame_start;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output frame_start, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input frame_start, output ready);
endinterface

interface rcc_res_if;
    logic          valid;
    logic          ready;
    rcc_pkg::chan_t red_out;
    rcc_pkg::chan_t green_out;
    rcc_pkg::chan_t blue_out;
    logic          frame_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output frame_last, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input frame_last, output ready);
endinterface

/* design/rcc_line_buffer.sv */
// ----------------------------------------------------------------------------
// rcc_line_buffer: line store memory
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module rcc_line_buffer #(
    parameter int DEPTH  = rcc_pkg::MAX_LINE_DEF,
    parameter int DATA_W = 2 * rcc_pkg::PIXEL_W
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Storage and read register; read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/rcc_window.sv */
// ----------------------------------------------------------------------------
// rcc_window: position tracking, line stores and 3x3 window
// Accepts pixels, reads the two stored lines, shifts the window and hands the
// nine taps of each interior pixel on to the multiply stage.
// ----------------------------------------------------------------------------
module rcc_window #(
    parameter int MAX_LINE = rcc_pkg::MAX_LINE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rcc_pix_if.sink                     pixels,
    input  logic [$clog2(MAX_LINE)-1:0] col_last,
    input  logic [rcc_pkg::ROW_W-1:0]   row_last,
    output rcc_pkg::window_t            win,
    output logic                        win_valid,
    input  logic                        win_ready
);
    import rcc_pkg::*;

    localparam int COL_W   = $clog2(MAX_LINE);
    localparam int ENTRY_W = 2 * PIXEL_W;

    // Position counters
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic             eol;
    logic             eof;
    logic             emit;
    logic             accept;

    // Stage 1: accepted pixel
    logic             s1_valid_reg;
    pixel_t           s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_last_reg;
    logic             s1_emit_reg;
    logic             s1_fire;
    logic             slot_free;

    // Line store access and forwarding
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0] wr_data;
    logic               fwd_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    pixel_t             above;
    pixel_t             above2;

    // Window and stage 2
    pixel_t [2:0][1:0]  win_reg;
    pixel_t [2:0]       colpix;
    logic               win_valid_reg;
    window_t            win_data_reg;

    assign accept = pixels.valid && pixels.ready;

    // Position of the incoming pixel and its line and frame flags
    always_comb
    begin
        col_cur = pixels.frame_start ? '0 : col_reg;
        row_cur = pixels.frame_start ? '0 : row_reg;
        eol     = col_cur >= col_last;
        eof     = eol && (row_cur >= row_last);
        emit    = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
    end

    // Counter update on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (eof)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (eol)
            begin
                col_reg <= '0;
                row_reg <= row_cur + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_cur + COL_W'(1);
                row_reg <= row_cur;
            end
        end
    end

    // Stage 1 leaves when the tap register has room, or at once for a border pixel.
    assign slot_free    = !win_valid_reg || win_ready;
    assign s1_fire      = s1_valid_reg && (slot_free || !s1_emit_reg);
    assign pixels.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_fire && (col_cur == s1_col_reg);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= {pixels.red_in, pixels.green_in, pixels.blue_in};
            s1_col_reg   <= col_cur;
            s1_last_reg  <= eof;
            s1_emit_reg  <= emit;
            fwd_data_reg <= wr_data;
        end
    end

    // Each entry packs the line above (upper half) and the line two above.
    rcc_line_buffer #(
        .DEPTH  (MAX_LINE),
        .DATA_W (ENTRY_W)
    ) u_lines (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (rd_data)
    );

    // A write to the same column in the cycle of the read is taken from the bypass.
    always_comb
    begin
        entry     = fwd_reg ? fwd_data_reg : rd_data;
        above     = entry[ENTRY_W-1:PIXEL_W];
        above2    = entry[PIXEL_W-1:0];
        wr_data   = {s1_pix_reg, above};
        colpix[0] = above2;
        colpix[1] = above;
        colpix[2] = s1_pix_reg;
    end

    // Window shift, one column per pixel in order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_fire)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= colpix[r];
            end
        end
    end

    // Stage 2: taps of an interior pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            win_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && s1_valid_reg && s1_emit_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_data_reg.tap[r][0] <= win_reg[r][0];
                win_data_reg.tap[r][1] <= win_reg[r][1];
                win_data_reg.tap[r][2] <= colpix[r];
            end
            win_data_reg.last <= s1_last_reg;
        end
    end

    assign win       = win_data_reg;
    assign win_valid = win_valid_reg;

endmodule

/* design/rcc_mac.sv */
// ----------------------------------------------------------------------------
// rcc_mac: kernel multiply, sum and clamp
// Multiplies the nine taps of each channel by the kernel, sums, clamps to
// 0..255 and holds the result in the output register.
// ----------------------------------------------------------------------------
module rcc_mac #(
    parameter int COEF_FRAC_BITS = rcc_pkg::COEF_FRAC_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rcc_pkg::window_t win,
    input  logic             win_valid,
    output logic             win_ready,
    input  rcc_pkg::kernel_t kernel,
    rcc_res_if.source        results
);
    import rcc_pkg::*;

    // Stage 3: products
    logic signed [PROD_W-1:0] prod_next [CHANNELS][TAPS];
    logic signed [PROD_W-1:0] prod_reg  [CHANNELS][TAPS];
    logic                     s3_valid_reg;
    logic                     s3_last_reg;

    // Stage 4: output register
    logic signed [SUM_W-1:0]  sum_next [CHANNELS];
    chan_t                    chan_next [CHANNELS];
    logic                     out_valid_reg;
    chan_t                    red_reg;
    chan_t                    green_reg;
    chan_t                    blue_reg;
    logic                     last_reg;
    logic                     out_free;
    logic                     s3_free;

    assign out_free  = !out_valid_reg || results.ready;
    assign s3_free   = !s3_valid_reg || out_free;
    assign win_ready = s3_free;

    // Nine signed coefficient by unsigned pixel products per channel
    always_comb
    begin
        logic signed [COEF_W-1:0] coef;
        logic signed [CHAN_W:0]   pix;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    coef = signed'(kernel[r][COEF_W*c +: COEF_W]);
                    pix  = signed'({1'b0, chan_of(win.tap[r][c], ch)});
                    prod_next[ch][r*3+c] = coef * pix;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_free)
        begin
            s3_valid_reg <= win_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_free && win_valid)
        begin
            prod_reg    <= prod_next;
            s3_last_reg <= win.last;
        end
    end

    // Sum of products, then floor to integer and clamp to 0..255
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            sum_next[ch] = '0;
            for (int t = 0; t < TAPS; t++)
            begin
                sum_next[ch] = sum_next[ch] + SUM_W'(prod_reg[ch][t]);
            end
            if (sum_next[ch][SUM_W-1])
            begin
                chan_next[ch] = '0;
            end
            else if (|sum_next[ch][SUM_W-2:COEF_FRAC_BITS+CHAN_W])
            begin
                chan_next[ch] = '1;
            end
            else
            begin
                chan_next[ch] = sum_next[ch][COEF_FRAC_BITS+CHAN_W-1:COEF_FRAC_BITS];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s3_valid_reg)
        begin
            red_reg   <= chan_next[0];
            green_reg <= chan_next[1];
            blue_reg  <= chan_next[2];
            last_reg  <= s3_last_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.red_out    = red_reg;
    assign results.green_out  = green_reg;
    assign results.blue_out   = blue_reg;
    assign results.frame_last = last_reg;

endmodule

/* design/rgb_conv3x3_clamped_unit.sv */
// ----------------------------------------------------------------------------
// rgb_conv3x3_clamped_unit: 3x3 RGB convolution with clamped output
//
//   channel   direction  transfer when          payload
//   pixels    in         valid && ready         red_in green_in blue_in frame_start
//   results   out        valid && ready         red_out green_out blue_out frame_last
//   cfg       in         cfg_we high            cfg_index cfg_data
//
// One pixel is accepted per clock unless the results side stalls; a window's
// result passes stage 1 and the tap, product and output registers in order.
// The rate is set by one line store read and one write per cycle.
// Reset clears the position counters, the window and all valid flags; the
// line stores are not cleared. A stall on the results side fills the four
// stages before the pixel channel stops; border pixels never wait for a slot.
// ----------------------------------------------------------------------------
module rgb_conv3x3_clamped_unit #(
    parameter int MAX_LINE       = rcc_pkg::MAX_LINE_DEF,
    parameter int COEF_FRAC_BITS = rcc_pkg::COEF_FRAC_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rcc_pix_if.sink                         pixels,
    rcc_res_if.source                       results,
    input  logic                            cfg_we,
    input  logic [rcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rcc_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE);

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    kernel_t                 kernel_reg;
    logic [COL_W-1:0]        col_last;
    logic [ROW_W-1:0]        row_last;
    window_t                 win;
    logic                    win_valid;
    logic                    win_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            kernel_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:   width_reg     <= cfg_data[WIDTH_REG_W-1:0];
                REG_FRAME_HEIGHT:  height_reg    <= cfg_data[HEIGHT_REG_W-1:0];
                REG_KERNEL_TOP:    kernel_reg[0] <= cfg_data[KERNEL_REG_W-1:0];
                REG_KERNEL_MID:    kernel_reg[1] <= cfg_data[KERNEL_REG_W-1:0];
                REG_KERNEL_BOTTOM: kernel_reg[2] <= cfg_data[KERNEL_REG_W-1:0];
                default:           ;
            endcase
        end
    end

    // Last column and last row, with the geometry saturated to its legal range
    always_comb
    begin
        if (width_reg < WIDTH_REG_W'(3))
        begin
            col_last = COL_W'(2);
        end
        else if (32'(width_reg) > MAX_LINE)
        begin
            col_last = COL_W'(MAX_LINE - 1);
        end
        else
        begin
            col_last = COL_W'(width_reg - WIDTH_REG_W'(1));
        end

        if (height_reg < HEIGHT_REG_W'(3))
        begin
            row_last = ROW_W'(2);
        end
        else if (height_reg > HEIGHT_REG_W'(HEIGHT_MAX))
        begin
            row_last = ROW_W'(HEIGHT_MAX - 1);
        end
        else
        begin
            row_last = ROW_W'(height_reg - HEIGHT_REG_W'(1));
        end
    end

    rcc_window #(
        .MAX_LINE (MAX_LINE)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels),
        .col_last  (col_last),
        .row_last  (row_last),
        .win       (win),
        .win_valid (win_valid),
        .win_ready (win_ready)
    );

    rcc_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .win       (win),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .kernel    (kernel_reg),
        .results   (results)
    );

endmodule

/* bench/rgb_conv3x3_clamped_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_conv3x3_clamped_unit_test: self-checking bench for the 3x3 RGB filter
// Drives pixel frames of varied geometry and kernels into the unit, predicts
// each filtered interior pixel in step with the accepted transfers and checks
// every result transfer, under random idling, long output stalls and pauses.
// ----------------------------------------------------------------------------
module rgb_conv3x3_clamped_unit_test;

    import rcc_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PIPE_SLACK   = 8;
    localparam int RANDOM_ITEMS = 470;
    localparam int GAP_PERCENT  = 28;
    localparam int REPORT_LIMIT = 10;
    localparam int WIDE_LINE    = 60;
    localparam int TALL_LINES   = 40;

    // One filtered pixel as it leaves the unit
    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  last;
    } filtered_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rcc_pix_if pix_ch ();
    rcc_res_if res_ch ();

    rgb_conv3x3_clamped_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_ch),
        .results   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Filter state as the bench believes it to be
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    kernel_t                 kernel_reg;
    pixel_t                  line_above     [MAX_LINE_DEF];
    pixel_t                  line_two_above [MAX_LINE_DEF];
    pixel_t                  window_cols    [3][2];
    int unsigned             next_col;
    int unsigned             next_row;
    filtered_t               filtered_q [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  hold_left      = 0;
    bit  send_gaps      = 1'b1;
    bit  take_gaps      = 1'b1;

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int unsigned line_length();
        int unsigned w;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > MAX_LINE_DEF) w = MAX_LINE_DEF;
        return w;
    endfunction

    function automatic int unsigned frame_lines();
        int unsigned h;
        h = height_reg;
        if (h < 3) h = 3;
        if (h > HEIGHT_MAX) h = HEIGHT_MAX;
        return h;
    endfunction

    // Negative sums give black; the rest are floored and saturated at white.
    function automatic chan_t clamp_sum(input longint acc);
        longint shifted;
        if (acc < 0)
            return '0;
        shifted = acc >>> COEF_FRAC_DEF;
        if (shifted > 255)
            return 8'hFF;
        return chan_t'(shifted);
    endfunction

    task automatic reset_prediction();
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        kernel_reg = '0;
        for (int i = 0; i < MAX_LINE_DEF; i++)
        begin
            line_above[i]     = '0;
            line_two_above[i] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            window_cols[i][0] = '0;
            window_cols[i][1] = '0;
        end
        next_col = 0;
        next_row = 0;
    endtask

    // Advance the filter by one accepted pixel and queue any result it causes.
    task automatic predict_pixel(input pixel_t px, input logic fs);
        int unsigned              w;
        int unsigned              h;
        int unsigned              c;
        int unsigned              r;
        pixel_t                   column [3];
        pixel_t                   taps [3][3];
        logic                     eol;
        logic                     eof;
        longint                   acc;
        logic signed [COEF_W-1:0] coef;
        chan_t                    level [3];
        filtered_t                res;
        w = line_length();
        h = frame_lines();
        if (fs)
        begin
            next_col = 0;
            next_row = 0;
        end
        c = (next_col >= MAX_LINE_DEF) ? MAX_LINE_DEF - 1 : next_col;
        r = next_row;
        column[0] = line_two_above[c];
        column[1] = line_above[c];
        column[2] = px;
        for (int i = 0; i < 3; i++)
        begin
            taps[i][0] = window_cols[i][0];
            taps[i][1] = window_cols[i][1];
            taps[i][2] = column[i];
        end
        eol = (c >= w - 1);
        eof = eol && (r >= h - 1);

        // Interior pixel: correlate each channel with the kernel
        if (r >= 2 && c >= 2)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                acc = 0;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                    begin
                        coef = kernel_reg[i][16*j +: 16];
                        acc += longint'(coef) * longint'(taps[i][j][(2-ch)*8 +: 8]);
                    end
                level[ch] = clamp_sum(acc);
            end
            res.red   = level[0];
            res.green = level[1];
            res.blue  = level[2];
            res.last  = eof;
            filtered_q = {filtered_q, res};
        end

        // Shift the window and the line stores, then move the position on
        for (int i = 0; i < 3; i++)
        begin
            window_cols[i][0] = window_cols[i][1];
            window_cols[i][1] = column[i];
        end
        line_two_above[c] = column[1];
        line_above[c]     = px;
        if (eof)
        begin
            next_col = 0;
            next_row = 0;
        end
        else if (eol)
        begin
            next_col = 0;
            next_row = (r + 1) & 12'hFFF;
        end
        else
            next_col = c + 1;
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, long hold-offs, checking
    // ------------------------------------------------------------------

    task automatic check_result();
        filtered_t got;
        filtered_t want;
        got.red   = res_ch.red_out;
        got.green = res_ch.green_out;
        got.blue  = res_ch.blue_out;
        got.last  = res_ch.frame_last;
        if (filtered_q.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result r=%0d g=%0d b=%0d last=%0b",
                         got.red, got.green, got.blue, got.last);
        end
        else
        begin
            want = filtered_q.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.last !== want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result mismatch: expected r=%0d g=%0d b=%0d last=%0b,",
                             want.red, want.green, want.blue, want.last,
                             " got r=%0d g=%0d b=%0d last=%0b",
                             got.red, got.green, got.blue, got.last);
            end
        end
    endtask

    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                check_result();
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= !(take_gaps && ($urandom_range(0, 99) < GAP_PERCENT));
        end
    end

    // ------------------------------------------------------------------
    // Pixel side and configuration
    // ------------------------------------------------------------------

    // Offer one pixel, wait for its transfer and predict its effect.
    task automatic send_pixel(input pixel_t px, input logic fs);
        while (send_gaps && ($urandom_range(0, 99) < GAP_PERCENT))
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.red_in      <= px.r;
        pix_ch.green_in    <= px.g;
        pix_ch.blue_in     <= px.b;
        pix_ch.frame_start <= fs;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        predict_pixel(px, fs);
    endtask

    task automatic pause_sender();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_results();
        while (filtered_q.size() != 0)
            @(posedge clk);
    endtask

    // Border pixels may still be in flight once the last result is in.
    task automatic go_idle();
        pause_sender();
        wait_results();
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:   width_reg     = value[WIDTH_REG_W-1:0];
            REG_FRAME_HEIGHT:  height_reg    = value[HEIGHT_REG_W-1:0];
            REG_KERNEL_TOP:    kernel_reg[0] = value[KERNEL_REG_W-1:0];
            REG_KERNEL_MID:    kernel_reg[1] = value[KERNEL_REG_W-1:0];
            REG_KERNEL_BOTTOM: kernel_reg[2] = value[KERNEL_REG_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_filter(input logic [CFG_DATA_W-1:0] w,
                              input logic [CFG_DATA_W-1:0] h,
                              input kernel_t               k);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_KERNEL_TOP, k[0]);
        write_reg(REG_KERNEL_MID, k[1]);
        write_reg(REG_KERNEL_BOTTOM, k[2]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic chan_t random_chan();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return chan_t'($urandom_range(0, 255));
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        px.r = random_chan();
        px.g = random_chan();
        px.b = random_chan();
        return px;
    endfunction

    function automatic kernel_t uniform_kernel(input logic [COEF_W-1:0] coef);
        kernel_t k;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                k[i][16*j +: 16] = coef;
        return k;
    endfunction

    // Full-range, small signed, or small positive coefficients
    function automatic kernel_t random_kernel();
        kernel_t k;
        int      style;
        int      v;
        style = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                case (style)
                    0:       v = int'($urandom_range(0, 65535));
                    3:       v = int'($urandom_range(0, 400));
                    default: v = int'($urandom_range(0, 3072)) - 1536;
                endcase
                k[i][16*j +: 16] = v[15:0];
            end
        return k;
    endfunction

    // A run of random pixels, optionally opening a frame, with stray frame starts.
    task automatic send_run(input int unsigned count, input logic first_start,
                            input int unsigned noise_pct);
        logic fs;
        for (int unsigned n = 0; n < count; n++)
        begin
            fs = (n == 0 && first_start) || ($urandom_range(0, 99) < noise_pct);
            send_pixel(random_pixel(), fs);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Smallest frames: identity, largest and most negative coefficients,
    // both saturated geometry registers and a frame that follows without a start.
    task automatic test_extremes();
        kernel_t k;
        pixel_t  px;
        k = '0;
        k[1][16 +: 16] = 16'h0400;
        for (int f = 0; f < 3; f++)
        begin
            case (f)
                0:       set_filter('0, '0, k);
                1:       set_filter(3, 3, uniform_kernel(16'h7FFF));
                default: set_filter(2, 1, uniform_kernel(16'h8000));
            endcase
            for (int n = 0; n < 9; n++)
            begin
                px.r = n[0] ? 8'hFF : 8'h00;
                px.g = (n % 3 == 0) ? 8'hFF : 8'h00;
                px.b = chan_t'(n * 37 + f * 90);
                send_pixel(px, (n == 0) && (f != 1));
            end
            go_idle();
        end
    endtask

    // Narrower lines and fewer lines set while a frame is under way.
    task automatic test_midframe_resize();
        set_filter(8, 6, random_kernel());
        send_run(20, 1'b1, 0);
        go_idle();
        // column 4 is already past the new last column: the line ends at once
        write_reg(REG_FRAME_WIDTH, 4);
        send_run(9, 1'b0, 0);
        go_idle();
        // row 5 is past the new last row: this line closes the frame
        write_reg(REG_FRAME_HEIGHT, 4);
        send_run(4, 1'b0, 0);
        go_idle();
    endtask

    // The result side holds off while pixels keep coming, then the sender
    // stops until every result is out and then sends a second run.
    task automatic test_output_stall();
        set_filter(20, 6, random_kernel());
        send_gaps = 1'b0;
        hold_left = 300;
        send_run(60, 1'b1, 0);
        pause_sender();
        wait_results();
        send_run(60, 1'b0, 0);
        send_gaps = 1'b1;
        go_idle();
    endtask

    // One frame of long lines through a sharpening kernel, with no idling.
    task automatic test_widest_line();
        kernel_t k;
        k = '0;
        k[0][16 +: 16] = 16'hFC00;
        k[1][0 +: 16]  = 16'hFC00;
        k[1][16 +: 16] = 16'h1400;
        k[1][32 +: 16] = 16'hFC00;
        k[2][16 +: 16] = 16'hFC00;
        set_filter(WIDE_LINE, 3, k);
        send_gaps = 1'b0;
        take_gaps = 1'b0;
        send_run(3 * WIDE_LINE, 1'b1, 0);
        go_idle();
        send_gaps = 1'b1;
        take_gaps = 1'b1;
    endtask

    // A tall frame on the narrowest lines.
    task automatic test_tallest_frame();
        set_filter(3, TALL_LINES, uniform_kernel(16'd114));
        send_run(3 * TALL_LINES, 1'b1, 0);
        go_idle();
    endtask

    // Mostly whole frames of random size and content; some cut short, some
    // with stray frame starts, some with the sender pausing mid-frame.
    task automatic test_random_frames();
        int unsigned sent;
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned frames;
        int unsigned n;
        int          pick;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                w_raw = $urandom_range(0, 2);
            else if (pick < 4)
                w_raw = $urandom_range(13, 40);
            else
                w_raw = $urandom_range(3, 12);
            h_raw = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            set_filter(CFG_DATA_W'(w_raw), CFG_DATA_W'(h_raw), random_kernel());
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames && sent < RANDOM_ITEMS; f++)
            begin
                n = line_length() * frame_lines();
                if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(1, n);
                // The last frame of the run is cut to the item budget.
                if (n > RANDOM_ITEMS - sent)
                    n = RANDOM_ITEMS - sent;
                if (n >= 4 && $urandom_range(0, 7) == 0)
                begin
                    send_run(n / 2, f == 0, 2);
                    pause_sender();
                    wait_results();
                    send_run(n - n / 2, 1'b0, 2);
                end
                else
                    send_run(n, f == 0, 2);
                sent += n;
            end
            go_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        pix_ch.valid       <= 1'b0;
        pix_ch.red_in      <= '0;
        pix_ch.green_in    <= '0;
        pix_ch.blue_in     <= '0;
        pix_ch.frame_start <= 1'b0;
        reset_prediction();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_midframe_resize();
        test_output_stall();
        test_widest_line();
        test_tallest_frame();
        test_random_frames();

        wait_results();
        repeat (2 * PIPE_SLACK) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
